// File: rtl/tts_pkg.sv
// Shared constants and types for the target tracking scale recommender.
// Used by every module under rtl; no dependencies of its own.
package tts_pkg;

   // History length and the widths that follow from it.
   localparam int HISTORY_DEPTH = 64;
   localparam int IDX_W         = $clog2(HISTORY_DEPTH);
   localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);

   // Field widths.
   localparam int SAMPLE_W = 14;
   localparam int READY_W  = 16;
   localparam int WIN_W    = 7;
   localparam int REC_W    = 23;
   localparam int PROD_W   = READY_W + SAMPLE_W;
   localparam int DIVCNT_W = $clog2(PROD_W);

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MARGIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IN_WINDOW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WINDOW = 2'd3;

   // Reset values of the registers.
   localparam logic [SAMPLE_W-1:0] TARGET_RESET     = 14'd7000;
   localparam logic [SAMPLE_W-1:0] MARGIN_RESET     = 14'd1000;
   localparam logic [WIN_W-1:0]    IN_WINDOW_RESET  = 7'd10;
   localparam logic [WIN_W-1:0]    OUT_WINDOW_RESET = 7'd3;

   // Hysteresis band, rounding tolerance scale and output ceiling.
   localparam int PCT_EPS_BP = 100;
   localparam int EPS_SCALE  = 1000;
   localparam logic [REC_W-1:0] OUT_MAX = 23'd8388607;

   typedef logic [SAMPLE_W-1:0] sample_type;

endpackage

// File: rtl/tts_cell.sv
// One history cell: holds a usage sample, loads from its left neighbor
// when a new item enters and from its right neighbor during a scan rotation.
// Depends on tts_pkg.
module tts_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  logic                rotate_en,
   input  tts_pkg::sample_type left_value,
   input  tts_pkg::sample_type right_value,
   output tts_pkg::sample_type cell_value
);
   import tts_pkg::*;

   sample_type value_ff;
   sample_type value_in;

   // Insert shifts toward the old end; rotation brings older samples to the head.
   always_comb begin
      value_in = value_ff;
      if (shift_en) begin
         value_in = left_value;
      end else if (rotate_en) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

// File: rtl/tts_divider.sv
// Restoring divider, one quotient bit per cycle, for the scaled node count.
// Depends on tts_pkg.
module tts_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tts_pkg::PROD_W-1:0]     dividend,
   input  logic [tts_pkg::SAMPLE_W-1:0]   divisor,
   output logic                           done,
   output logic [tts_pkg::PROD_W-1:0]     quotient,
   output logic [tts_pkg::SAMPLE_W-1:0]   remainder
);
   import tts_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIVCNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [SAMPLE_W-1:0] div_ff, div_in;
   logic [SAMPLE_W:0]   trial;
   logic                fits;

   // Bring down the next dividend bit and try the subtraction.
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_W-2:0], fits};
         rem_in = fits ? SAMPLE_W'(trial - {1'b0, div_ff}) : trial[SAMPLE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIVCNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/target_tracking_scale_recommender.sv
// Top level of the target tracking scale recommender: history cell chain,
// window scan at the chain head, serial divider and result register.
// Depends on tts_pkg, tts_cell and tts_divider.
//
//  channel | direction | fields (lowest bit up)
//  --------+-----------+-----------------------------------------------------
//  req_*   | in        | tdata: usage_sample[13:0], ready_nodes[29:14], zero pad
//  rsp_*   | out       | tdata: recommended_nodes[22:0], zero pad;
//          |           | tuser: scaled_in[0], scaled_out[1]
//  csr_*   | in        | write: target, margin, in window, out window
//
// An item is taken in, the cell chain then rotates once per history entry, and
// one multiply follows. When a window holds, the item is launched into the
// divider, which works through PROD_W quotient bits and raises its done flag,
// and the result is rounded and delivered. Without a held window the divider
// is skipped.
// Reset is synchronous; history cells are not cleared, the fill count is.
// A finished item waits in the output register while the next item is taken.
module target_tracking_scale_recommender (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // usage_sample, ready_nodes
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // recommended_nodes
   output logic [1:0]                      rsp_tuser,   // scaled_in, scaled_out
   input  logic                            csr_we,
   input  logic [tts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tts_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_LAUNCH = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_ROUND  = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;

   // Configuration registers.
   logic [SAMPLE_W-1:0] target_ff, margin_ff;
   logic [WIN_W-1:0]    win_in_ff, win_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= TARGET_RESET;
         margin_ff  <= MARGIN_RESET;
         win_in_ff  <= IN_WINDOW_RESET;
         win_out_ff <= OUT_WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET:     target_ff  <= csr_wdata;
            REG_MARGIN:     margin_ff  <= csr_wdata;
            REG_IN_WINDOW:  win_in_ff  <= csr_wdata[WIN_W-1:0];
            REG_OUT_WINDOW: win_out_ff <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Thresholds, divisor follow the registers; user must change them only while idle, unchecked.
   logic signed [15:0]  thr_in;
   logic [14:0]         thr_out;
   logic [SAMPLE_W-1:0] divisor;

   assign thr_in  = $signed({2'b00, target_ff}) - $signed({2'b00, margin_ff})
                    - 16'(PCT_EPS_BP);
   assign thr_out = {1'b0, target_ff} + 15'(PCT_EPS_BP);
   assign divisor = (target_ff == '0) ? SAMPLE_W'(1) : target_ff;

   // Control and working registers.
   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                in_ok_ff, in_ok_in;
   logic                out_ok_ff, out_ok_in;
   sample_type          max_in_ff, max_in_in;
   sample_type          max_out_ff, max_out_in;
   logic [READY_W-1:0]  ready_ff, ready_in;
   logic [PROD_W-1:0]   product_ff, product_in;
   logic                rup_ff, rup_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [REC_W-1:0]    rec_ff, rec_in;
   logic                sin_ff, sin_in;
   logic                sout_ff, sout_in;

   logic                req_fire;
   logic                rotate;
   logic                div_start;
   logic                div_done;
   logic [PROD_W-1:0]   div_quo;
   logic [SAMPLE_W-1:0] div_rem;
   logic [COUNT_W-1:0]  count_next;
   sample_type          head;
   sample_type          sel_max;
   logic                in_win, out_win;
   logic                head_le, head_ge;
   logic [PROD_W:0]     rounded;
   logic [REC_W-1:0]    rec_value;
   logic                rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rotate     = (state_ff == ST_SCAN);
   assign div_start  = (state_ff == ST_LAUNCH);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // History cell chain; cell 0 is the head and holds the newest sample.
   sample_type chain [HISTORY_DEPTH];

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      sample_type left_value;
      if (i == 0) begin : g_head
         assign left_value = req_tdata[SAMPLE_W-1:0];
      end else begin : g_body
         assign left_value = chain[i-1];
      end
      tts_cell u_cell (
         .clock       (clock),
         .shift_en    (req_fire),
         .rotate_en   (rotate),
         .left_value  (left_value),
         .right_value (chain[(i + 1) % HISTORY_DEPTH]),
         .cell_value  (chain[i])
      );
   end

   tts_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (product_ff),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Window tests on the sample now at the chain head.
   assign head    = chain[0];
   assign in_win  = 32'(scan_ff) < 32'(win_in_ff);
   assign out_win = 32'(scan_ff) < 32'(win_out_ff);
   assign head_le = !thr_in[15] && ({2'b00, head} <= thr_in[15:0]);
   assign head_ge = {1'b0, head} >= thr_out;
   assign sel_max = out_ok_ff ? max_out_ff : max_in_ff;

   assign count_next = (32'(count_ff) < HISTORY_DEPTH) ? count_ff + 1'b1 : count_ff;

   // Round up unless the fraction is below the tolerance, then saturate.
   assign rounded = {1'b0, div_quo} + (PROD_W+1)'(rup_ff);

   always_comb begin
      if (!(in_ok_ff || out_ok_ff)) begin
         rec_value = REC_W'(ready_ff);
      end else if (rounded > (PROD_W+1)'(OUT_MAX)) begin
         rec_value = OUT_MAX;
      end else begin
         rec_value = rounded[REC_W-1:0];
      end
      if (rec_value == '0) begin
         rec_value = REC_W'(1);
      end
   end

   // Sequencer: enter, scan, multiply, then launch, divide and round when a window holds, deliver.
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      in_ok_in     = in_ok_ff;
      out_ok_in    = out_ok_ff;
      max_in_in    = max_in_ff;
      max_out_in   = max_out_ff;
      ready_in     = ready_ff;
      product_in   = product_ff;
      rup_in       = rup_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rec_in       = rec_ff;
      sin_in       = sin_ff;
      sout_in      = sout_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in   = count_next;
               ready_in   = req_tdata[SAMPLE_W +: READY_W];
               in_ok_in   = (win_in_ff != '0) && (32'(win_in_ff) <= 32'(count_next));
               out_ok_in  = (win_out_ff != '0) && (32'(win_out_ff) <= 32'(count_next));
               max_in_in  = '0;
               max_out_in = '0;
               scan_in    = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (in_win) begin
               in_ok_in = in_ok_ff && head_le;
               if (head > max_in_ff) begin
                  max_in_in = head;
               end
            end
            if (out_win) begin
               out_ok_in = out_ok_ff && head_ge;
               if (head > max_out_ff) begin
                  max_out_in = head;
               end
            end
            if (scan_ff == IDX_W'(HISTORY_DEPTH - 1)) begin
               scan_in  = '0;
               state_in = ST_MUL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_MUL: begin
            product_in = PROD_W'(ready_ff) * PROD_W'(sel_max);
            rup_in     = 1'b0;
            state_in   = (in_ok_ff || out_ok_ff) ? ST_LAUNCH : ST_FIN;
         end
         ST_LAUNCH: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            rup_in   = (32'(div_rem) * 32'(EPS_SCALE)) >= 32'(divisor);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rec_in       = rec_value;
               sin_in       = in_ok_ff;
               sout_in      = out_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_ok_ff   <= in_ok_in;
      out_ok_ff  <= out_ok_in;
      max_in_ff  <= max_in_in;
      max_out_ff <= max_out_in;
      ready_ff   <= ready_in;
      product_ff <= product_in;
      rup_ff     <= rup_in;
      rec_ff     <= rec_in;
      sin_ff     <= sin_in;
      sout_ff    <= sout_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rec_ff};
   assign rsp_tuser  = {sout_ff, sin_ff};

   // The chain must be back in place, with the scan index at zero, when idle.
   a_scan_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (scan_ff == '0))
      else $error("scan index not at zero while idle");

   // The divider finishes only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // A delivered node count is never zero.
   a_rec_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[REC_W-1:0] != '0))
      else $error("recommended node count is zero");

endmodule
